/* src/kns_pkg.sv */
// Package: shared constants, codes and controller/datapath interface types for the k-nearest selector.
package kns_pkg;

  // Default number of neighbors the store is sized for.
  localparam int MaxNeighborsDefault = 16;
  // Hard ceiling on the store depth.
  localparam int StoreDepthCap = 16;

  localparam int KindW   = 2;
  localparam int IdW     = 16;
  localparam int DistW   = 32;
  localparam int KCountW = 5;
  localparam logic [KCountW-1:0] KCountReset = 5'd16;

  typedef enum logic [KindW-1:0] {
    KIND_START  = 2'd0,
    KIND_CAND   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic start;       // clear store, record query id
    logic cand;        // offer a candidate to the store
    logic load_first;  // load the first result into the output register
    logic load_next;   // load the following result
    logic k_we;        // write the neighbor count register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_last;    // output register holds the final result of the list
  } stat_t;

endpackage

/* src/kns_ctrl.sv */
// Controller: sequences input beats, list emission and register writes.
module kns_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  kns_pkg::kind_t       in_kind,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  kns_pkg::stat_t       stat,
  output kns_pkg::cmd_t        cmd
);

  kns_pkg::state_t state, state_next;

  // Hold the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode beats into commands and advance the state.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cfg_ready  = 1'b1;
    cmd.k_we   = cfg_valid;
    case (state)
      kns_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_kind)
            kns_pkg::KIND_START: cmd.start = 1'b1;
            kns_pkg::KIND_CAND:  cmd.cand  = 1'b1;
            kns_pkg::KIND_FINISH: begin
              cmd.load_first = 1'b1;
              state_next     = kns_pkg::ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      kns_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.out_last) begin
            state_next = kns_pkg::ST_IDLE;
          end else begin
            cmd.load_next = 1'b1;
          end
        end
      end
      default: state_next = kns_pkg::ST_IDLE;
    endcase
  end

endmodule

/* src/kns_datapath.sv */
// Datapath: sorted insertion cells, query and count registers, result register.
module kns_datapath #(
  parameter int MAX_NEIGHBORS = kns_pkg::MaxNeighborsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kns_pkg::cmd_t               cmd,
  input  logic [kns_pkg::IdW-1:0]     query_id,
  input  logic [kns_pkg::IdW-1:0]     candidate_id,
  input  logic [kns_pkg::DistW-1:0]   distance,
  input  logic [kns_pkg::KCountW-1:0] k_data,
  output kns_pkg::stat_t              stat,
  output logic [kns_pkg::IdW-1:0]     neighbor_id,
  output logic [kns_pkg::DistW-1:0]   neighbor_distance,
  output logic                        found,
  output logic                        last
);

  localparam int Depth = (MAX_NEIGHBORS < kns_pkg::StoreDepthCap) ?
                         MAX_NEIGHBORS : kns_pkg::StoreDepthCap;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [kns_pkg::IdW-1:0]     ids   [Depth];
  logic [kns_pkg::DistW-1:0]   dists [Depth];
  logic [CntW-1:0]             count;
  logic [kns_pkg::IdW-1:0]     query;
  logic [kns_pkg::KCountW-1:0] k_reg;
  logic [IdxW-1:0]             emit_idx;

  logic [CntW-1:0] k_eff;
  logic [CntW-1:0] n_emit;
  logic [CntW-1:0] n_ins;
  logic [IdxW-1:0] tail_idx;
  logic [Depth-1:0] lt;
  logic [Depth-1:0] keep;
  logic             full;
  logic             ins_en;
  logic [IdxW-1:0]  idx_sel;
  logic             sel_found;
  logic             sel_last;

  // Clamp the neighbor count to 1..Depth.
  always_comb begin
    if (k_reg == '0) begin
      k_eff = CntW'(1);
    end else if (k_reg > kns_pkg::KCountW'(Depth)) begin
      k_eff = CntW'(Depth);
    end else begin
      k_eff = k_reg[CntW-1:0];
    end
  end

  assign n_emit   = (count < k_eff) ? count : k_eff;
  assign full     = (count >= k_eff);
  assign tail_idx = IdxW'(count - CntW'(1));

  // Decide whether a candidate enters the store and over how many entries.
  always_comb begin
    ins_en = 1'b0;
    n_ins  = count;
    if (candidate_id != query) begin
      if (!full) begin
        ins_en = 1'b1;
      end else if (count != '0 && lt[tail_idx]) begin
        ins_en = 1'b1;
        n_ins  = count - CntW'(1);
      end
    end
  end

  // Insertion cells: keep, shift down, or take the new entry.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign lt[i]   = distance < dists[i];
    assign keep[i] = (CntW'(i) < n_ins) && !lt[i];

    always_ff @(posedge clk) begin
      if (cmd.cand && ins_en && !keep[i]) begin
        if (i == 0) begin
          ids[i]   <= candidate_id;
          dists[i] <= distance;
        end else if (keep[(i > 0) ? i - 1 : 0]) begin
          ids[i]   <= candidate_id;
          dists[i] <= distance;
        end else begin
          ids[i]   <= ids[(i > 0) ? i - 1 : 0];
          dists[i] <= dists[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Track query, fill count and neighbor count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      query <= '0;
      k_reg <= kns_pkg::KCountReset;
    end else begin
      if (cmd.k_we) begin
        k_reg <= k_data;
      end
      if (cmd.start) begin
        count <= '0;
        query <= query_id;
      end else if (cmd.cand && ins_en) begin
        count <= n_ins + CntW'(1);
      end
    end
  end

  // Pick the entry for the next result.
  assign idx_sel   = cmd.load_first ? '0 : emit_idx + IdxW'(1);
  assign sel_found = (n_emit != '0);
  assign sel_last  = !sel_found || ((CntW'(idx_sel) + CntW'(1)) == n_emit);

  // Load the result register.
  always_ff @(posedge clk) begin
    if (cmd.load_first || cmd.load_next) begin
      emit_idx          <= idx_sel;
      neighbor_id       <= sel_found ? ids[idx_sel]   : '0;
      neighbor_distance <= sel_found ? dists[idx_sel] : '0;
      found             <= sel_found;
      last              <= sel_last;
    end
  end

  assign stat.out_last = last;

endmodule

/* src/k_nearest_selector_core.sv */
// Top level: k-nearest selector with stream input, stream output and a count register port.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tuser kind, tdata ids and distance
//  m_*     | out       | m_tvalid/m_tready  | tdata id and distance, tuser found, tlast
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_data neighbor count
//
// Start and candidate beats are taken while the block is idle; insertion into the sorted cells
// completes in the cycle the beat is accepted.
// A finish beat loads the first result into the result register, shown in the next cycle,
// then one result per cycle while m_tready is high; no input is taken until the last result has gone out.
// Reset clears the fill count and query id and sets the neighbor count to 16.
// A stall on the output holds the result and keeps the input closed.
module k_nearest_selector_core #(
  parameter int MAX_NEIGHBORS = kns_pkg::MaxNeighborsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // query_id[15:0], candidate_id[31:16], distance[63:32]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // neighbor_id[15:0], neighbor_distance[47:16]
  output logic [0:0]  m_tuser,   // found[0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  kns_pkg::cmd_t  cmd;
  kns_pkg::stat_t stat;
  logic [kns_pkg::IdW-1:0]   neighbor_id;
  logic [kns_pkg::DistW-1:0] neighbor_distance;
  logic                      found;

  kns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (kns_pkg::kind_t'(s_tuser)),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kns_datapath #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .query_id          (s_tdata[15:0]),
    .candidate_id      (s_tdata[31:16]),
    .distance          (s_tdata[63:32]),
    .k_data            (cfg_data),
    .stat              (stat),
    .neighbor_id       (neighbor_id),
    .neighbor_distance (neighbor_distance),
    .found             (found),
    .last              (m_tlast)
  );

  assign m_tdata = {neighbor_distance, neighbor_id};
  assign m_tuser = found;

`ifndef SYNTH
  // Input and output never open together.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  // An empty-list result is always the final one.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("empty-list result without last");

  // A finish beat produces a result in the next cycle.
  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == kns_pkg::KIND_FINISH) |=> m_tvalid)
    else $error("finish beat did not start the list");

  // Once the last result is taken, the input reopens.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not reopened after the list");
`endif

endmodule
